>>> hdl/gray_code_stripe_pattern_generator_top_macros.svh
// Assertion macros shared by the verification files of the stripe pattern generator.
// Depends on nothing; expects i_clk and i_rst_n in the scope of use.
`ifndef GRAY_CODE_STRIPE_PATTERN_GENERATOR_TOP_MACROS_SVH
`define GRAY_CODE_STRIPE_PATTERN_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset
`define GCSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define GCSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/gcsp_pkg.sv
// Package of the Gray-code stripe pattern generator: widths, limits, register codes.
// Used by the top level and by its checker; depends on nothing.
package gcsp_pkg;

    // field and counter widths
    localparam int DIG_W      = 5;
    localparam int RES_W      = 13;
    localparam int POS_W      = 12;
    localparam int IMG_W      = 5;
    localparam int IMGS_W     = 6;
    localparam int PIX_W      = 8;
    localparam int SIDX_W     = 13;
    localparam int SOFF_W     = 12;
    localparam int GRAY_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // limits and constant values
    localparam logic [RES_W-1:0]  MAX_RES    = 13'd4096;
    localparam logic [DIG_W-1:0]  MAX_DIGITS = 5'd16;
    localparam logic [SIDX_W-1:0] SIDX_MAX   = 13'd8191;
    localparam logic [PIX_W-1:0]  PIX_ON     = 8'hFF;
    localparam logic [PIX_W-1:0]  PIX_OFF    = 8'h00;

    // register reset values
    localparam logic [DIG_W-1:0] RST_NUM_DIGITS = 5'd6;
    localparam logic             RST_LINE_BASED = 1'b1;
    localparam logic [RES_W-1:0] RST_RES_ROWS   = 13'd768;
    localparam logic [RES_W-1:0] RST_RES_COLS   = 13'd1024;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_DIGITS = 2'd0,
        CFG_LINE_BASED = 2'd1,
        CFG_RES_ROWS   = 2'd2,
        CFG_RES_COLS   = 2'd3
    } t_cfg_idx;

endpackage

>>> hdl/gray_code_stripe_pattern_generator_top.sv
// Top level of the Gray-code stripe pattern generator: counters, stripe tracking, output register.
// Depends on gcsp_pkg.
//
// Streams the pixels of a structured-light Gray-code sequence, one 8-bit pixel (0 or 255) per
// accepted input word, with its image number, row, column and end-of-image/end-of-sequence
// flags. Images come in pairs, normal then inverted; pair p shows bit p of the Gray code of the
// stripe index. Every input word yields exactly one output word, registered in the cycle after acceptance;
// a new word can be taken every cycle, and the single output register keeps accepting while
// the downstream side drains it, so the rate is one pixel per clock unless the output stalls.
// Setting restart on a word starts the sequence over at its first pixel. Register writes are
// always ready and take effect on the next word; write them only while the stream is idle.
module gray_code_stripe_pattern_generator_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input words
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_restart,
    // output words
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [gcsp_pkg::PIX_W-1:0]          o_pixel,
    output logic [gcsp_pkg::IMG_W-1:0]          o_image_index,
    output logic [gcsp_pkg::POS_W-1:0]          o_row,
    output logic [gcsp_pkg::POS_W-1:0]          o_col,
    output logic                                o_last_of_image,
    output logic                                o_last_of_sequence,
    // register writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  gcsp_pkg::t_cfg_idx                  i_cfg_index,
    input  logic [gcsp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import gcsp_pkg::*;

    // configuration registers
    logic [DIG_W-1:0]  r_num_digits;
    logic              r_line_based;
    logic [RES_W-1:0]  r_res_rows;
    logic [RES_W-1:0]  r_res_cols;

    // position state
    logic [POS_W-1:0]  r_row_count,  n_row_count;
    logic [POS_W-1:0]  r_col_count,  n_col_count;
    logic [IMG_W-1:0]  r_image_count, n_image_count;
    logic [SIDX_W-1:0] r_stripe_index, n_stripe_index;
    logic [SOFF_W-1:0] r_stripe_offset, n_stripe_offset;

    // output register
    logic              r_out_valid;
    logic [PIX_W-1:0]  r_pixel, n_pixel;
    logic [IMG_W-1:0]  r_image_index;
    logic [POS_W-1:0]  r_row, r_col;
    logic              r_last_img, r_last_seq;

    // working signals
    logic              in_accept;
    logic [DIG_W-1:0]  digits;
    logic [RES_W-1:0]  rows, cols, axis_res, space;
    logic [IMGS_W-1:0] images, images_last;
    logic              clear;
    logic [POS_W-1:0]  cur_row, cur_col;
    logic [IMG_W-1:0]  cur_img;
    logic [SIDX_W-1:0] cur_sidx, sidx_inc;
    logic [SOFF_W-1:0] cur_soff;
    logic [RES_W-1:0]  soff_inc;
    logic [GRAY_W-1:0] gray;
    logic              gray_bit, in_range;
    logic              last_col, last_row, last_img, last_seq;

    // handshakes
    assign o_stall     = r_out_valid && i_stall;
    assign in_accept   = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    // clamp registers into their working ranges
    always_comb begin
        if (r_num_digits == '0) begin
            digits = DIG_W'(1);
        end else if (r_num_digits > MAX_DIGITS) begin
            digits = MAX_DIGITS;
        end else begin
            digits = r_num_digits;
        end
        if (r_res_rows == '0) begin
            rows = RES_W'(1);
        end else if (r_res_rows > MAX_RES) begin
            rows = MAX_RES;
        end else begin
            rows = r_res_rows;
        end
        if (r_res_cols == '0) begin
            cols = RES_W'(1);
        end else if (r_res_cols > MAX_RES) begin
            cols = MAX_RES;
        end else begin
            cols = r_res_cols;
        end
    end

    assign images      = {1'b0, digits} << 1;
    assign images_last = images - IMGS_W'(1);
    assign axis_res    = r_line_based ? cols : rows;
    assign space       = axis_res >> digits;

    // restart, or position left outside the current bounds
    assign clear = i_restart
                || ({1'b0, r_row_count} >= rows)
                || ({1'b0, r_col_count} >= cols)
                || ({1'b0, r_image_count} >= images);

    assign cur_row  = clear ? '0 : r_row_count;
    assign cur_col  = clear ? '0 : r_col_count;
    assign cur_img  = clear ? '0 : r_image_count;
    assign cur_sidx = clear ? '0 : r_stripe_index;
    assign cur_soff = clear ? '0 : r_stripe_offset;

    // pixel: Gray bit of the stripe, cleared from stripe index 2**digits on and when the stripe width is zero
    assign gray     = GRAY_W'(cur_sidx ^ (cur_sidx >> 1));
    assign gray_bit = gray[cur_img[IMG_W-1:1]];
    assign in_range = (cur_sidx >> digits) == '0;

    always_comb begin
        n_pixel = (space != '0 && in_range && gray_bit) ? PIX_ON : PIX_OFF;
        if (cur_img[0]) begin
            n_pixel = ~n_pixel;
        end
    end

    assign last_col = ({1'b0, cur_col} == cols - RES_W'(1));
    assign last_row = ({1'b0, cur_row} == rows - RES_W'(1));
    assign last_img = last_col && last_row;
    assign last_seq = last_img && ({1'b0, cur_img} == images_last);

    // stripe counter step
    assign soff_inc = {1'b0, cur_soff} + RES_W'(1);
    assign sidx_inc = (cur_sidx != SIDX_MAX) ? cur_sidx + SIDX_W'(1) : cur_sidx;

    always_comb begin
        n_stripe_index  = cur_sidx;
        n_stripe_offset = cur_soff;
        if ((r_line_based && last_col) || (!r_line_based && last_img)) begin
            n_stripe_index  = '0;
            n_stripe_offset = '0;
        end else if (r_line_based || last_col) begin
            if (soff_inc >= space) begin
                n_stripe_offset = '0;
                n_stripe_index  = sidx_inc;
            end else begin
                n_stripe_offset = soff_inc[SOFF_W-1:0];
            end
        end
    end

    // raster counters
    always_comb begin
        n_row_count   = cur_row;
        n_col_count   = cur_col;
        n_image_count = cur_img;
        if (last_col) begin
            n_col_count = '0;
            if (last_row) begin
                n_row_count   = '0;
                n_image_count = last_seq ? '0 : cur_img + IMG_W'(1);
            end else begin
                n_row_count = cur_row + POS_W'(1);
            end
        end else begin
            n_col_count = cur_col + POS_W'(1);
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_digits <= RST_NUM_DIGITS;
            r_line_based <= RST_LINE_BASED;
            r_res_rows   <= RST_RES_ROWS;
            r_res_cols   <= RST_RES_COLS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_NUM_DIGITS: r_num_digits <= i_cfg_data[DIG_W-1:0];
                CFG_LINE_BASED: r_line_based <= i_cfg_data[0];
                CFG_RES_ROWS:   r_res_rows   <= i_cfg_data[RES_W-1:0];
                CFG_RES_COLS:   r_res_cols   <= i_cfg_data[RES_W-1:0];
                default: ;
            endcase
        end
    end

    // position state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count     <= '0;
            r_col_count     <= '0;
            r_image_count   <= '0;
            r_stripe_index  <= '0;
            r_stripe_offset <= '0;
        end else if (in_accept) begin
            r_row_count     <= n_row_count;
            r_col_count     <= n_col_count;
            r_image_count   <= n_image_count;
            r_stripe_index  <= n_stripe_index;
            r_stripe_offset <= n_stripe_offset;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pixel       <= n_pixel;
            r_image_index <= cur_img;
            r_row         <= cur_row;
            r_col         <= cur_col;
            r_last_img    <= last_img;
            r_last_seq    <= last_seq;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_pixel            = r_pixel;
    assign o_image_index      = r_image_index;
    assign o_row              = r_row;
    assign o_col              = r_col;
    assign o_last_of_image    = r_last_img;
    assign o_last_of_sequence = r_last_seq;

endmodule

>>> hdl/gcsp_checker.sv
// Port-level checker for the Gray-code stripe pattern generator, bound to its top level.
// Depends on gcsp_pkg and gray_code_stripe_pattern_generator_top_macros.svh.
`include "gray_code_stripe_pattern_generator_top_macros.svh"

module gcsp_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                o_stall,
    input  logic                                i_restart,
    input  logic                                o_valid,
    input  logic                                i_stall,
    input  logic [gcsp_pkg::PIX_W-1:0]          o_pixel,
    input  logic [gcsp_pkg::IMG_W-1:0]          o_image_index,
    input  logic [gcsp_pkg::POS_W-1:0]          o_row,
    input  logic [gcsp_pkg::POS_W-1:0]          o_col,
    input  logic                                o_last_of_image,
    input  logic                                o_last_of_sequence
);
    import gcsp_pkg::*;

    logic                               pixel_ok;
    logic                               restart_acc;
    logic                               at_origin;
    logic [PIX_W+IMG_W+2*POS_W-1:0]     out_word;

    // terms used by the properties
    assign pixel_ok    = (o_pixel == PIX_ON) || (o_pixel == PIX_OFF);
    assign restart_acc = i_valid && !o_stall && i_restart;
    assign at_origin   = (o_image_index == '0) && (o_row == '0) && (o_col == '0);
    assign out_word    = {o_pixel, o_image_index, o_row, o_col};

    // pixel is fully on or fully off
    `GCSP_ASSERT_NOW(a_pixel_binary, o_valid, pixel_ok, "pixel not 0 or 255")

    // end of sequence only on an end of image
    `GCSP_ASSERT_NOW(a_seq_in_image, o_valid && o_last_of_sequence, o_last_of_image, "seq end off image end")

    // accepted restart word comes out as the first pixel of image 0
    `GCSP_ASSERT_NEXT(a_restart_origin, restart_acc, o_valid && at_origin, "restart missed origin")

    // a stalled output word holds
    `GCSP_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(out_word), "stalled word changed")

endmodule

bind gray_code_stripe_pattern_generator_top gcsp_checker u_gcsp_checker (.*);
